/* design/tsg_pkg.sv */
// Shared types and constants for the tempo step gate.
`default_nettype none

package tsg_pkg;

    // Operand and product widths of the shared multiplier.
    localparam int unsigned MUL_A_W = 33;
    localparam int unsigned MUL_B_W = 18;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // Unity in Q1.16 and the lowest legal step count.
    localparam logic [16:0] UNITY     = 17'h10000;
    localparam logic [4:0]  MIN_STEPS = 5'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GATE_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_STEP_COUNT   = 3'd1;
    localparam logic [2:0] CFG_STEP_PATTERN = 3'd2;
    localparam logic [2:0] CFG_PHASE_STEP   = 3'd3;
    localparam logic [2:0] CFG_ATTACK       = 3'd4;
    localparam logic [2:0] CFG_RELEASE      = 3'd5;
    localparam logic [2:0] CFG_MIX_AMOUNT   = 3'd6;

    // Current configuration as seen by the sequencer.
    typedef struct packed {
        logic        gate_enable;
        logic [4:0]  step_count;
        logic [15:0] step_pattern;
        logic [31:0] phase_step;
        logic [15:0] attack_coefficient;
        logic [15:0] release_coefficient;
        logic [16:0] mix_amount;
    } t_cfg;

endpackage

`default_nettype wire

/* design/tsg_regs.sv */
// Configuration register file of the tempo step gate.
`default_nettype none

module tsg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output tsg_pkg::t_cfg    o_cfg
);
    import tsg_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken; an index past the list is dropped.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_enable         <= 1'b1;
            r_cfg.step_count          <= 5'd8;
            r_cfg.step_pattern        <= 16'hAAAA;
            r_cfg.phase_step          <= 32'd178957;
            r_cfg.attack_coefficient  <= 16'd6554;
            r_cfg.release_coefficient <= 16'd6554;
            r_cfg.mix_amount          <= UNITY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GATE_ENABLE:  r_cfg.gate_enable         <= i_cfg_data[0];
                CFG_STEP_COUNT:   r_cfg.step_count          <= i_cfg_data[4:0];
                CFG_STEP_PATTERN: r_cfg.step_pattern        <= i_cfg_data[15:0];
                CFG_PHASE_STEP:   r_cfg.phase_step          <= i_cfg_data;
                CFG_ATTACK:       r_cfg.attack_coefficient  <= i_cfg_data[15:0];
                CFG_RELEASE:      r_cfg.release_coefficient <= i_cfg_data[15:0];
                CFG_MIX_AMOUNT:   r_cfg.mix_amount          <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/tsg_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module tsg_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [tsg_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic signed [tsg_pkg::MUL_B_W-1:0]  i_b,
    output logic signed      [tsg_pkg::PROD_W-1:0]   o_prod
);
    import tsg_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // One product per cycle, registered before any use.
    // Both operands are widened first so the full product is kept.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* design/tsg_seq.sv */
// Sequencer and datapath: phase, step index, envelope smoother, gain and scaling.
`default_nettype none

module tsg_seq #(
    parameter int PATTERN_STEPS = 16,
    parameter int SAMPLE_BITS   = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tsg_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_right_sample,
    input  wire logic                               i_load_phase,
    input  wire logic [31:0]                        i_start_phase,
    output logic signed      [tsg_pkg::MUL_A_W-1:0] o_mul_a,
    output logic signed      [tsg_pkg::MUL_B_W-1:0] o_mul_b,
    input  wire logic signed [tsg_pkg::PROD_W-1:0]  i_prod,
    input  wire logic                               i_out_free,
    output logic                                    o_res_valid,
    output logic signed      [SAMPLE_BITS-1:0]      o_left_out,
    output logic signed      [SAMPLE_BITS-1:0]      o_right_out,
    output logic [16:0]                             o_gain_value,
    output logic [3:0]                              o_step_index
);
    import tsg_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_IDX   = 4'd1;
    localparam logic [3:0] ST_ENV   = 4'd2;
    localparam logic [3:0] ST_UPD   = 4'd3;
    localparam logic [3:0] ST_GAIN  = 4'd4;
    localparam logic [3:0] ST_GSUM  = 4'd5;
    localparam logic [3:0] ST_LEFT  = 4'd6;
    localparam logic [3:0] ST_RIGHT = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    localparam logic [4:0] MAX_STEPS = 5'(PATTERN_STEPS);
    localparam int unsigned EXT_W    = MUL_A_W - SAMPLE_BITS;

    logic [3:0]                    r_state, n_state;
    logic [31:0]                   r_phase, n_phase;
    logic [16:0]                   r_env, n_env;
    logic signed [SAMPLE_BITS-1:0] r_left, n_left;
    logic signed [SAMPLE_BITS-1:0] r_right, n_right;
    logic signed [SAMPLE_BITS-1:0] r_left_out, n_left_out;
    logic [3:0]                    r_idx, n_idx;
    logic [16:0]                   r_diff, n_diff;
    logic                          r_up, n_up;
    logic [16:0]                   r_gain, n_gain;

    logic [4:0]  steps;
    logic [16:0] mix_c;
    logic [3:0]  idx_now;
    logic        open_bit;
    logic [16:0] diff_now;
    logic [33:0] round_sum;
    logic [17:0] delta;
    logic [16:0] delta_c;
    logic [33:0] gain_sum;
    logic [17:0] gain_raw;

    // Clamped configuration values.
    always_comb begin
        if (i_cfg.step_count < MIN_STEPS) begin
            steps = MIN_STEPS;
        end else if (i_cfg.step_count > MAX_STEPS) begin
            steps = MAX_STEPS;
        end else begin
            steps = i_cfg.step_count;
        end
        mix_c = (i_cfg.mix_amount > UNITY) ? UNITY : i_cfg.mix_amount;
    end

    // Step lookup, smoother and gain terms taken from the registered product.
    always_comb begin
        idx_now   = i_prod[35:32];
        open_bit  = i_cfg.step_pattern[idx_now];
        diff_now  = open_bit ? (UNITY - r_env) : r_env;
        round_sum = 34'(i_prod[33:0]) + 34'd32768;
        delta     = round_sum[33:16];
        delta_c   = (delta > {1'b0, r_diff}) ? r_diff : delta[16:0];
        gain_sum  = 34'(i_prod[33:0]) + {1'b0, UNITY - mix_c, 16'd0} + 34'd32768;
        gain_raw  = gain_sum[33:16];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            ST_IDX: begin
                o_mul_a = {1'b0, r_phase};
                o_mul_b = {13'd0, steps};
            end
            ST_ENV: begin
                o_mul_a = {17'd0, (open_bit && (r_env != UNITY)) ?
                           i_cfg.attack_coefficient : i_cfg.release_coefficient};
                o_mul_b = {1'b0, diff_now};
            end
            ST_GAIN: begin
                o_mul_a = {16'd0, r_env};
                o_mul_b = {1'b0, mix_c};
            end
            ST_LEFT: begin
                o_mul_a = {{EXT_W{r_left[SAMPLE_BITS-1]}}, r_left};
                o_mul_b = {1'b0, r_gain};
            end
            ST_RIGHT, ST_FIN: begin
                o_mul_a = {{EXT_W{r_right[SAMPLE_BITS-1]}}, r_right};
                o_mul_b = {1'b0, r_gain};
            end
            default: begin
                o_mul_a = '0;
                o_mul_b = '0;
            end
        endcase
    end

    // Next-state and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_env      = r_env;
        n_left     = r_left;
        n_right    = r_right;
        n_left_out = r_left_out;
        n_idx      = r_idx;
        n_diff     = r_diff;
        n_up       = r_up;
        n_gain     = r_gain;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_left  = i_left_sample;
                    n_right = i_right_sample;
                    if (i_cfg.gate_enable) begin
                        n_phase = (i_load_phase ? i_start_phase : r_phase) +
                                  i_cfg.phase_step;
                        n_state = ST_IDX;
                    end else begin
                        // Bypass: unity gain leaves the samples unchanged.
                        n_gain  = UNITY;
                        n_idx   = 4'd0;
                        n_state = ST_LEFT;
                    end
                end
            end
            ST_IDX: begin
                n_state = ST_ENV;
            end
            ST_ENV: begin
                n_idx   = idx_now;
                n_diff  = diff_now;
                n_up    = open_bit;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_env   = r_up ? (r_env + delta_c) : (r_env - delta_c);
                n_state = ST_GAIN;
            end
            ST_GAIN: begin
                n_state = ST_GSUM;
            end
            ST_GSUM: begin
                n_gain  = (gain_raw > {1'b0, UNITY}) ? UNITY : gain_raw[16:0];
                n_state = ST_LEFT;
            end
            ST_LEFT: begin
                n_state = ST_RIGHT;
            end
            ST_RIGHT: begin
                n_left_out = i_prod[SAMPLE_BITS+15:16];
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and smoother state take reset; payload does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_env   <= n_env;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_right    <= n_right;
        r_left_out <= n_left_out;
        r_idx      <= n_idx;
        r_diff     <= n_diff;
        r_up       <= n_up;
        r_gain     <= n_gain;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_res_valid  = (r_state == ST_FIN) && i_out_free;
    assign o_left_out   = r_left_out;
    assign o_right_out  = i_prod[SAMPLE_BITS+15:16];
    assign o_gain_value = r_gain;
    assign o_step_index = r_idx;

endmodule

`default_nettype wire

/* design/tempo_step_gate.sv */
// Top level of the tempo step gate: registers, sequencer, multiplier, result register.
//
//   channel   direction  handshake                   payload
//   input     in         i_valid / o_ready           left, right, load_phase, start_phase
//   result    out        o_valid / i_ready           left_out, right_out, gain, step_index
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A gated request makes the single multiplier do five passes (step index, smoother,
// gain, left, right) before the next request can be accepted; a bypassed request
// makes only the left and right passes. The result is offered from the result register
// once the sequencer leaves its final state.
// Synchronous active-low reset clears the phase, the envelope and all handshakes.
// A result held by a stalled consumer blocks only the end of the following request.
`default_nettype none

module tempo_step_gate #(
    parameter int PATTERN_STEPS = 16,
    parameter int SAMPLE_BITS   = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  wire logic                          i_load_phase,
    input  wire logic [31:0]                   i_start_phase,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed      [SAMPLE_BITS-1:0] o_left_out,
    output logic signed      [SAMPLE_BITS-1:0] o_right_out,
    output logic [16:0]                        o_gain_value,
    output logic [3:0]                         o_step_index,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    import tsg_pkg::*;

    t_cfg                          cfg;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic                          out_free;
    logic                          res_valid;
    logic signed [SAMPLE_BITS-1:0] res_left;
    logic signed [SAMPLE_BITS-1:0] res_right;
    logic [16:0]                   res_gain;
    logic [3:0]                    res_idx;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;
    logic [16:0]                   r_gain_value;
    logic [3:0]                    r_step_index;

    tsg_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tsg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    tsg_seq #(
        .PATTERN_STEPS (PATTERN_STEPS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_load_phase   (i_load_phase),
        .i_start_phase  (i_start_phase),
        .o_mul_a        (mul_a),
        .o_mul_b        (mul_b),
        .i_prod         (prod),
        .i_out_free     (out_free),
        .o_res_valid    (res_valid),
        .o_left_out     (res_left),
        .o_right_out    (res_right),
        .o_gain_value   (res_gain),
        .o_step_index   (res_idx)
    );

    // The result register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_left_out   <= res_left;
            r_right_out  <= res_right;
            r_gain_value <= res_gain;
            r_step_index <= res_idx;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_left_out   = r_left_out;
    assign o_right_out  = r_right_out;
    assign o_gain_value = r_gain_value;
    assign o_step_index = r_step_index;

endmodule

`default_nettype wire

/* tb/tsg_gate_checker.sv */
// Scoreboard for the tempo step gate: predicts every gated sample pair and checks the results.
module tsg_gate_checker #(
    parameter int PATTERN_STEPS = 16,
    parameter int SAMPLE_BITS   = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  wire logic                          i_load_phase,
    input  wire logic [31:0]                   i_start_phase,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_out,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_out,
    input  wire logic [16:0]                   i_gain_value,
    input  wire logic [3:0]                    i_step_index,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import tsg_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [16:0]                   gain;
        logic [3:0]                    step;
    } t_gated_pair;

    // Expected results in request order, plus a private copy of the block's state.
    t_gated_pair expected_pairs[$];
    t_cfg        gate_regs;
    logic [31:0] phase_acc;
    logic [16:0] envelope;
    int          fail_total;
    int          checked_total;

    // Advance the sequencer by one sample and return the gated pair it should produce.
    function automatic t_gated_pair predict_gated_pair(
        input logic signed [SAMPLE_BITS-1:0] left,
        input logic signed [SAMPLE_BITS-1:0] right,
        input logic                          load,
        input logic [31:0]                   start
    );
        t_gated_pair        res;
        logic [63:0]        wide;
        logic [4:0]         steps;
        logic [3:0]         idx;
        logic [16:0]        target;
        logic [16:0]        diff;
        logic [16:0]        mix;
        logic [15:0]        alpha;
        logic               rising;
        logic [63:0]        delta;
        logic [63:0]        gain;
        logic signed [63:0] sl;
        logic signed [63:0] sr;
        logic signed [63:0] gs;
        logic signed [63:0] scaled;

        // Bypass leaves the state alone and reports unity gain on step zero.
        if (!gate_regs.gate_enable) begin
            res.left  = left;
            res.right = right;
            res.gain  = UNITY;
            res.step  = '0;
            return res;
        end

        if (load)
            phase_acc = start;
        phase_acc = phase_acc + gate_regs.phase_step;

        steps = gate_regs.step_count;
        if (steps < MIN_STEPS)
            steps = MIN_STEPS;
        if (steps > PATTERN_STEPS)
            steps = 5'(PATTERN_STEPS);
        wide = 64'(phase_acc) * 64'(steps);
        idx  = wide[35:32];

        // One-pole smoother toward the open or closed level of the selected step.
        target = gate_regs.step_pattern[idx] ? UNITY : 17'd0;
        rising = target > envelope;
        alpha  = rising ? gate_regs.attack_coefficient : gate_regs.release_coefficient;
        diff   = rising ? target - envelope : envelope - target;
        delta  = (64'(alpha) * 64'(diff) + 64'd32768) >> 16;
        if (delta > 64'(diff))
            delta = 64'(diff);
        envelope = rising ? envelope + delta[16:0] : envelope - delta[16:0];

        // Depth blend, then floor-scaled samples.
        mix  = (gate_regs.mix_amount > UNITY) ? UNITY : gate_regs.mix_amount;
        gain = (64'(mix) * 64'(envelope) + 64'(UNITY - mix) * 64'(UNITY) + 64'd32768) >> 16;
        if (gain > 64'(UNITY))
            gain = 64'(UNITY);
        gs = $signed(gain);
        sl = left;
        sr = right;

        scaled    = (sl * gs) >>> 16;
        res.left  = scaled[SAMPLE_BITS-1:0];
        scaled    = (sr * gs) >>> 16;
        res.right = scaled[SAMPLE_BITS-1:0];
        res.gain  = gain[16:0];
        res.step  = idx;
        return res;
    endfunction

    // Watch all three channels at each edge; results are checked before new requests land.
    always @(posedge i_clk) begin : watch
        t_gated_pair want;
        t_gated_pair got;

        if (!i_rst_n) begin
            gate_regs.gate_enable         = 1'b1;
            gate_regs.step_count          = 5'd8;
            gate_regs.step_pattern        = 16'hAAAA;
            gate_regs.phase_step          = 32'd178957;
            gate_regs.attack_coefficient  = 16'd6554;
            gate_regs.release_coefficient = 16'd6554;
            gate_regs.mix_amount          = UNITY;
            phase_acc                     = '0;
            envelope                      = '0;
            expected_pairs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GATE_ENABLE:  gate_regs.gate_enable         = i_cfg_data[0];
                    CFG_STEP_COUNT:   gate_regs.step_count          = i_cfg_data[4:0];
                    CFG_STEP_PATTERN: gate_regs.step_pattern        = i_cfg_data[15:0];
                    CFG_PHASE_STEP:   gate_regs.phase_step          = i_cfg_data;
                    CFG_ATTACK:       gate_regs.attack_coefficient  = i_cfg_data[15:0];
                    CFG_RELEASE:      gate_regs.release_coefficient = i_cfg_data[15:0];
                    CFG_MIX_AMOUNT:   gate_regs.mix_amount          = i_cfg_data[16:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                got.left  = i_left_out;
                got.right = i_right_out;
                got.gain  = i_gain_value;
                got.step  = i_step_index;
                if (expected_pairs.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected result: L=%0d R=%0d gain=%0d step=%0d",
                                 got.left, got.right, got.gain, got.step);
                end else begin
                    want = expected_pairs.pop_front();
                    checked_total++;
                    if (got.left !== want.left || got.right !== want.right ||
                        got.gain !== want.gain || got.step !== want.step) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("result %0d wrong: expected L=%0d R=%0d gain=%0d step=%0d, %s",
                                     checked_total, want.left, want.right, want.gain,
                                     want.step, "see actual below");
                        if (fail_total <= 10)
                            $display("  actual L=%0d R=%0d gain=%0d step=%0d",
                                     got.left, got.right, got.gain, got.step);
                    end
                end
            end

            if (i_in_valid && i_in_ready)
                expected_pairs.push_back(predict_gated_pair(i_left_sample, i_right_sample,
                                                            i_load_phase, i_start_phase));
        end

        o_fail_count <= fail_total;
        o_pending    <= expected_pairs.size();
        o_checked    <= checked_total;
    end

endmodule

/* tb/tb_tempo_step_gate.sv */
// Testbench top for the tempo step gate: stimulus, stall patterns and the final verdict.
module tb_tempo_step_gate;
    import tsg_pkg::*;

    localparam int PATTERN_STEPS = 16;
    localparam int SAMPLE_BITS   = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 73;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    // Index past the end of the register map; writes there must change nothing.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_left_sample  = '0;
    logic signed [SAMPLE_BITS-1:0] i_right_sample = '0;
    logic                          i_load_phase   = 1'b0;
    logic [31:0]                   i_start_phase  = '0;
    logic                          o_valid;
    logic                          i_ready        = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_left_out;
    logic signed [SAMPLE_BITS-1:0] o_right_out;
    logic [16:0]                   o_gain_value;
    logic [3:0]                    o_step_index;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [2:0]                    i_cfg_index    = '0;
    logic [31:0]                   i_cfg_data     = '0;

    int fail_count;
    int pending;
    int checked;
    int cycle_count      = 0;
    int samples_sent     = 0;
    int settings_applied = 0;
    bit quiet            = 1'b0;
    bit hold_off_armed   = 1'b0;

    tempo_step_gate #(
        .PATTERN_STEPS(PATTERN_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_left_sample (i_left_sample),
        .i_right_sample(i_right_sample),
        .i_load_phase  (i_load_phase),
        .i_start_phase (i_start_phase),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out),
        .o_gain_value  (o_gain_value),
        .o_step_index  (o_step_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tsg_gate_checker #(
        .PATTERN_STEPS(PATTERN_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_left_sample (i_left_sample),
        .i_right_sample(i_right_sample),
        .i_load_phase  (i_load_phase),
        .i_start_phase (i_start_phase),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_left_out    (o_left_out),
        .i_right_out   (o_right_out),
        .i_gain_value  (o_gain_value),
        .i_step_index  (o_step_index),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Clock with a 20-unit period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("tb_tempo_step_gate: done, errors");
            $finish;
        end
    end

    // Result consumer: short random stalls, one long hold-off on request, none when quiet.
    initial begin : consumer
        bit long_hold_done;
        long_hold_done = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_armed && !long_hold_done) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Mostly random full-scale samples, with the rails and zero mixed in.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return raw[SAMPLE_BITS-1:0];
        endcase
    endfunction

    // Fill the bits above a register's width with noise when asked to.
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width,
                                              input bit junk);
        logic [31:0] noise;
        noise = $urandom();
        if (!junk || width >= 32)
            return value;
        return value | (noise << width);
    endfunction

    // Register settings: fixed corners first, then random ones.
    function automatic t_cfg phase_setting(input int phase);
        t_cfg c;
        c.gate_enable         = ($urandom_range(0, 4) != 0);
        c.step_count          = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                            : 5'($urandom_range(4, 16));
        c.step_pattern        = 16'($urandom());
        c.phase_step          = $urandom() >> $urandom_range(0, 28);
        c.attack_coefficient  = ($urandom_range(0, 9) == 0) ? 16'd0
                                                            : 16'($urandom_range(1, 65535));
        c.release_coefficient = ($urandom_range(0, 9) == 0) ? 16'd0
                                                            : 16'($urandom_range(1, 65535));
        case ($urandom_range(0, 3))
            0:       c.mix_amount = 17'd0;
            1:       c.mix_amount = UNITY;
            2:       c.mix_amount = 17'($urandom_range(0, 131071));
            default: c.mix_amount = 17'($urandom_range(0, 65536));
        endcase
        case (phase)
            0: begin
                c.gate_enable         = 1'b1;
                c.step_count          = 5'd16;
                c.step_pattern        = 16'hFFFF;
                c.phase_step          = 32'hFFFF_FFFF;
                c.attack_coefficient  = 16'hFFFF;
                c.release_coefficient = 16'hFFFF;
                c.mix_amount          = UNITY;
            end
            1: begin
                c.gate_enable         = 1'b1;
                c.step_count          = 5'd0;
                c.step_pattern        = 16'h0000;
                c.phase_step          = 32'd0;
                c.attack_coefficient  = 16'd0;
                c.release_coefficient = 16'd0;
                c.mix_amount          = 17'h1FFFF;
            end
            2: begin
                c.gate_enable         = 1'b1;
                c.step_count          = 5'd31;
                c.step_pattern        = 16'h8001;
                c.phase_step          = 32'h0100_0000;
                c.attack_coefficient  = 16'd1;
                c.release_coefficient = 16'hFFFF;
                c.mix_amount          = 17'd0;
            end
            3: c.gate_enable = 1'b0;
            4: begin
                c.gate_enable         = 1'b1;
                c.step_count          = MIN_STEPS;
                c.phase_step          = 32'h0040_0000;
                c.attack_coefficient  = 16'hFFFF;
                c.release_coefficient = 16'd1;
                c.mix_amount          = 17'hFFFF;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Present one register write and hold it until taken; the caller lowers valid.
    task automatic cfg_write(input logic [2:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write every register back to back, plus one write to the unused index.
    task automatic apply_cfg(input t_cfg c, input bit junk);
        cfg_write(CFG_GATE_ENABLE,  with_junk(32'(c.gate_enable), 1, junk));
        cfg_write(CFG_STEP_COUNT,   with_junk(32'(c.step_count), 5, junk));
        cfg_write(CFG_STEP_PATTERN, with_junk(32'(c.step_pattern), 16, junk));
        cfg_write(CFG_PHASE_STEP,   c.phase_step);
        cfg_write(CFG_ATTACK,       with_junk(32'(c.attack_coefficient), 16, junk));
        cfg_write(CFG_RELEASE,      with_junk(32'(c.release_coefficient), 16, junk));
        cfg_write(CFG_MIX_AMOUNT,   with_junk(32'(c.mix_amount), 17, junk));
        cfg_write(CFG_UNUSED,       $urandom());
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Offer one sample request, wait until it is taken, then maybe idle for a short burst.
    task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] left,
                                input logic signed [SAMPLE_BITS-1:0] right,
                                input logic load, input logic [31:0] start);
        i_valid        <= 1'b1;
        i_left_sample  <= left;
        i_right_sample <= right;
        i_load_phase   <= load;
        i_start_phase  <= start;
        do @(posedge i_clk); while (!o_ready);
        samples_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence: directed corners on the reset settings, a bypass section, then random phases.
    initial begin : stimulus
        t_cfg setting;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rails and zero, then phase loads onto an open step, across the wrap and a closed one.
        offer_sample('0, '0, 1'b0, 32'd0);
        offer_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 32'd0);
        offer_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 32'hFFFF_FFFF);
        offer_sample('1, SAMPLE_BITS'(1), 1'b0, 32'd0);
        offer_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 32'h2000_0000);
        repeat (4) offer_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 32'd0);
        offer_sample(SAMPLE_MIN, SAMPLE_MIN, 1'b1, 32'hFFFF_FFFF);
        offer_sample(SAMPLE_MAX, '1, 1'b1, 32'd0);
        repeat (3) offer_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 32'd0);
        offer_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 32'hE000_0000);
        drain_results();

        // Bypass: samples pass unchanged and a phase load must be ignored.
        cfg_write(CFG_GATE_ENABLE, 32'd0);
        i_cfg_valid <= 1'b0;
        offer_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 32'h8000_0000);
        offer_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 32'd0);
        offer_sample('1, '0, 1'b1, 32'hFFFF_FFFF);
        drain_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            setting = phase_setting(phase);
            apply_cfg(setting, phase >= 3);
            if (phase == 2)
                hold_off_armed = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_sample(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0,
                             $urandom());
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample requests across %0d register settings plus reset defaults,",
                 samples_sent, settings_applied);
        $display("checked %0d results, with one long output stall and a bypass section.",
                 checked);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("tb_tempo_step_gate: done, clean");
        else
            $display("tb_tempo_step_gate: done, errors");
        $finish;
    end

endmodule
